/* src/oaids_pkg.sv */
// Shared types and constants for the ordered array insert, delete and search block.
`timescale 1ns / 1ps

package oaids_pkg;

    // Number of entries the list can hold
    localparam int CAPACITY = 64;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    typedef logic [IDX_W-1:0]  idx_t;
    typedef logic [CNT_W-1:0]  cnt_t;
    typedef logic signed [31:0] value_t;

    // Request codes
    typedef enum logic [2:0] {
        REQ_INS_FRONT = 3'd0,
        REQ_INS_END   = 3'd1,
        REQ_INS_AT    = 3'd2,
        REQ_DEL_LAST  = 3'd3,
        REQ_DEL_FIRST = 3'd4,
        REQ_DEL_AT    = 3'd5,
        REQ_SEARCH    = 3'd6,
        REQ_READ      = 3'd7
    } req_type_t;

    // Result status codes
    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_RANGE = 2'd1,
        STAT_EMPTY = 2'd2,
        STAT_FULL  = 2'd3
    } status_t;

endpackage

/* src/oaids_if.sv */
// Request and result channel interfaces for the ordered array block.
`timescale 1ns / 1ps

interface oaids_req_if;
    logic                     valid;
    logic                     ready;
    oaids_pkg::req_type_t     req_type;
    oaids_pkg::value_t        item_value;
    oaids_pkg::cnt_t          position;

    modport source (output valid, output req_type, output item_value, output position,
                    input ready);
    modport sink   (input valid, input req_type, input item_value, input position,
                    output ready);
endinterface

interface oaids_rsp_if;
    logic                     valid;
    logic                     ready;
    oaids_pkg::status_t       status;
    logic                     found;
    oaids_pkg::idx_t          found_index;
    oaids_pkg::value_t        read_value;
    oaids_pkg::cnt_t          entry_count;

    modport source (output valid, output status, output found, output found_index,
                    output read_value, output entry_count, input ready);
    modport sink   (input valid, input status, input found, input found_index,
                    input read_value, input entry_count, output ready);
endinterface

/* src/ordered_array_insert_delete_search_top.sv */
// Insert shifts up then puts, delete shifts down, search scans, read fetches the entry, and a
// rejected request goes straight to the result; each ends with the result handshake.
// Throughput: one request at a time; the shift and scan loops move one entry per cycle
// through the one-write, one-read store.
// Reset: rst_n (asynchronous, active low) empties the list; the store itself is not
// cleared, only entries below the count are ever used.
`timescale 1ns / 1ps

module ordered_array_insert_delete_search_top (
    input  logic               clk,
    input  logic               rst_n,
    oaids_req_if.sink          req,
    oaids_rsp_if.source        rsp
);
    import oaids_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SHIFT_UP,
        S_PUT,
        S_SHIFT_DN,
        S_SCAN,
        S_RD_ADDR,
        S_RD_DATA,
        S_RESP
    } state_t;

    state_t    state_reg, state_next;
    cnt_t      count_reg, count_next;
    cnt_t      ptr_reg, ptr_next;
    idx_t      at_reg, at_next;
    idx_t      waddr_reg, waddr_next;
    logic      pend_reg, pend_next;
    value_t    val_reg, val_next;
    status_t   status_reg, status_next;
    logic      found_reg, found_next;
    idx_t      fidx_reg, fidx_next;
    value_t    rval_reg, rval_next;

    // Entry store: one write and one registered read per cycle
    logic [31:0] store_mem [CAPACITY];
    logic [31:0] rd_data_reg;
    idx_t        rd_addr;
    idx_t        wr_addr;
    logic [31:0] wr_data;
    logic        wr_en;

    cnt_t        ins_at;
    cnt_t        del_at;
    cnt_t        ptr_dec;
    cnt_t        del_at_inc;

    assign req.ready       = (state_reg == S_IDLE);
    assign rsp.valid       = (state_reg == S_RESP);
    assign rsp.status      = status_reg;
    assign rsp.found       = found_reg;
    assign rsp.found_index = fidx_reg;
    assign rsp.read_value  = rval_reg;
    assign rsp.entry_count = count_reg;

    assign ptr_dec    = ptr_reg - cnt_t'(1);
    assign del_at_inc = del_at + cnt_t'(1);

    // Pick the target index of an incoming insert or delete
    always_comb
    begin
        case (req.req_type)
            REQ_INS_FRONT: ins_at = '0;
            REQ_INS_END:   ins_at = count_reg;
            default:       ins_at = req.position;
        endcase
        case (req.req_type)
            REQ_DEL_LAST:  del_at = count_reg - cnt_t'(1);
            REQ_DEL_FIRST: del_at = '0;
            default:       del_at = req.position;
        endcase
    end

    // Store port selection
    always_comb
    begin
        rd_addr = '0;
        case (state_reg)
            S_SHIFT_UP: rd_addr = ptr_dec[IDX_W-1:0];
            S_SHIFT_DN: rd_addr = ptr_reg[IDX_W-1:0];
            S_SCAN:     rd_addr = ptr_reg[IDX_W-1:0];
            S_RD_ADDR:  rd_addr = at_reg;
            default:    rd_addr = '0;
        endcase

        if (pend_reg && (state_reg == S_SHIFT_UP || state_reg == S_SHIFT_DN))
        begin
            wr_en   = 1'b1;
            wr_addr = waddr_reg;
            wr_data = rd_data_reg;
        end
        else if (state_reg == S_PUT)
        begin
            wr_en   = 1'b1;
            wr_addr = at_reg;
            wr_data = val_reg;
        end
        else
        begin
            wr_en   = 1'b0;
            wr_addr = waddr_reg;
            wr_data = rd_data_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= store_mem[rd_addr];
    end

    // Sequencer
    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        ptr_next    = ptr_reg;
        at_next     = at_reg;
        waddr_next  = waddr_reg;
        pend_next   = 1'b0;
        val_next    = val_reg;
        status_next = status_reg;
        found_next  = found_reg;
        fidx_next   = fidx_reg;
        rval_next   = rval_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    val_next    = req.item_value;
                    status_next = STAT_OK;
                    found_next  = 1'b0;
                    fidx_next   = '0;
                    rval_next   = '0;
                    state_next  = S_RESP;
                    case (req.req_type) inside
                        REQ_INS_FRONT, REQ_INS_END, REQ_INS_AT:
                        begin
                            if (count_reg == cnt_t'(CAPACITY))
                            begin
                                status_next = STAT_FULL;
                            end
                            else if (ins_at > count_reg)
                            begin
                                status_next = STAT_RANGE;
                            end
                            else
                            begin
                                ptr_next   = count_reg;
                                at_next    = ins_at[IDX_W-1:0];
                                state_next = S_SHIFT_UP;
                            end
                        end
                        REQ_DEL_LAST, REQ_DEL_FIRST, REQ_DEL_AT:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = STAT_EMPTY;
                            end
                            else if (del_at >= count_reg)
                            begin
                                status_next = STAT_RANGE;
                            end
                            else
                            begin
                                ptr_next   = del_at_inc;
                                state_next = S_SHIFT_DN;
                            end
                        end
                        REQ_SEARCH:
                        begin
                            ptr_next   = '0;
                            state_next = S_SCAN;
                        end
                        default:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = STAT_EMPTY;
                            end
                            else if (req.position >= count_reg)
                            begin
                                status_next = STAT_RANGE;
                            end
                            else
                            begin
                                at_next    = req.position[IDX_W-1:0];
                                state_next = S_RD_ADDR;
                            end
                        end
                    endcase
                end
            end

            // Move entries up one place, top first, then drop the value in
            S_SHIFT_UP:
            begin
                if (ptr_reg > cnt_t'(at_reg))
                begin
                    pend_next  = 1'b1;
                    waddr_next = ptr_reg[IDX_W-1:0];
                    ptr_next   = ptr_dec;
                end
                else
                begin
                    state_next = S_PUT;
                end
            end

            S_PUT:
            begin
                count_next = count_reg + cnt_t'(1);
                state_next = S_RESP;
            end

            // Move entries down one place, bottom first
            S_SHIFT_DN:
            begin
                if (ptr_reg < count_reg)
                begin
                    pend_next  = 1'b1;
                    waddr_next = ptr_dec[IDX_W-1:0];
                    ptr_next   = ptr_reg + cnt_t'(1);
                end
                else
                begin
                    count_next = count_reg - cnt_t'(1);
                    state_next = S_RESP;
                end
            end

            // Compare last entry read, else fetch the next one
            S_SCAN:
            begin
                if (pend_reg && (rd_data_reg == val_reg))
                begin
                    found_next = 1'b1;
                    fidx_next  = waddr_reg;
                    state_next = S_RESP;
                end
                else if (ptr_reg >= count_reg)
                begin
                    state_next = S_RESP;
                end
                else
                begin
                    pend_next  = 1'b1;
                    waddr_next = ptr_reg[IDX_W-1:0];
                    ptr_next   = ptr_reg + cnt_t'(1);
                end
            end

            S_RD_ADDR:
            begin
                state_next = S_RD_DATA;
            end

            S_RD_DATA:
            begin
                rval_next  = rd_data_reg;
                state_next = S_RESP;
            end

            // Hold the result until it is taken
            S_RESP:
            begin
                if (rsp.ready)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            pend_reg   <= 1'b0;
            ptr_reg    <= '0;
            at_reg     <= '0;
            waddr_reg  <= '0;
            val_reg    <= '0;
            status_reg <= STAT_OK;
            found_reg  <= 1'b0;
            fidx_reg   <= '0;
            rval_reg   <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            pend_reg   <= pend_next;
            ptr_reg    <= ptr_next;
            at_reg     <= at_next;
            waddr_reg  <= waddr_next;
            val_reg    <= val_next;
            status_reg <= status_next;
            found_reg  <= found_next;
            fidx_reg   <= fidx_next;
            rval_reg   <= rval_next;
        end
    end

endmodule
